// ===== sv/pgnms_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgnms_pkg
// Shared types and constants for the priority grid nearest-max selector.
// ----------------------------------------------------------------------------
package pgnms_pkg;

   localparam int COORD_W = 5;
   localparam int VALUE_W = 8;
   localparam int SUM_W   = 18;
   localparam int DIST_W  = 17;
   localparam logic [SUM_W-1:0] SUM_MAX = 18'h3FFFF;

   // transaction kind carried on req_tuser
   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_SEARCH = 1'b1;

   // controller -> datapath
   typedef struct packed {
      logic capture;     // latch the request transaction
      logic clr_we;      // clearing pass: zero one entry
      logic wr_rd;       // read the entry addressed by the write
      logic wr_we;       // write the entry and update the total
      logic scan_start;  // reset scan counters and best candidate
      logic scan_issue;  // issue one scan read
      logic load_out;    // load the result register
      logic out_search;  // result comes from the scan
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clr_last;
      logic scan_last;
      logic wr_ok;
   } status_type;

endpackage

// ===== sv/pgnms_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgnms_ctrl
// Sequencer: clearing pass, write read-modify-write, grid scan, result hand-off.
// ----------------------------------------------------------------------------
module pgnms_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_search,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  pgnms_pkg::status_type st,
   output pgnms_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WR_READ,
      ST_WR_UPD,
      ST_SCAN,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;
   logic      search_ff, search_in;
   logic      out_free;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = out_valid_ff;

   always_comb begin
      cmd            = '0;
      state_in       = state_ff;
      out_valid_in   = out_valid_ff && !rsp_tready;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_we = 1'b1;
            if (st.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture    = 1'b1;
               cmd.scan_start = req_search;
               state_in       = req_search ? ST_SCAN : ST_WR_READ;
            end
         end
         ST_WR_READ: begin
            cmd.wr_rd = 1'b1;
            state_in  = st.wr_ok ? ST_WR_UPD : ST_EMIT;
         end
         ST_WR_UPD: begin
            cmd.wr_we = 1'b1;
            state_in  = ST_EMIT;
         end
         ST_SCAN: begin
            cmd.scan_issue = 1'b1;
            if (st.scan_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            cmd.out_search = search_ff;
            if (out_free) begin
               cmd.load_out = 1'b1;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // remember the kind of the transaction in flight for the result select
   always_comb begin
      search_in = search_ff;
      if (cmd.capture) search_in = req_search;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         out_valid_ff <= 1'b0;
         search_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         search_ff    <= search_in;
      end
   end

endmodule

// ===== sv/pgnms_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgnms_datapath
// Grid memory, running total, scan counters, distance stage, best-cell compare
// and the result register.
// ----------------------------------------------------------------------------
module pgnms_datapath #(
   parameter int ROWS = 32,
   parameter int COLS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  pgnms_pkg::cmd_type                  cmd,
   output pgnms_pkg::status_type               st,
   input  logic [pgnms_pkg::COORD_W-1:0]       req_cell_row,
   input  logic [pgnms_pkg::COORD_W-1:0]       req_cell_col,
   input  logic [pgnms_pkg::VALUE_W-1:0]       req_cell_value,
   input  logic [pgnms_pkg::COORD_W-1:0]       req_pos_row,
   input  logic [pgnms_pkg::COORD_W-1:0]       req_pos_col,
   output logic [pgnms_pkg::COORD_W-1:0]       rsp_best_row,
   output logic [pgnms_pkg::COORD_W-1:0]       rsp_best_col,
   output logic [pgnms_pkg::VALUE_W-1:0]       rsp_best_value,
   output logic [pgnms_pkg::SUM_W-1:0]         rsp_remaining_sum
);

   localparam int CELLS   = ROWS * COLS;
   localparam int IDX_W   = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int RW      = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int CW      = (COLS > 1) ? $clog2(COLS) : 1;
   localparam int TOTAL_W = $clog2(255 * CELLS + 1);
   localparam int EXT_W   = (TOTAL_W > pgnms_pkg::SUM_W) ? TOTAL_W : pgnms_pkg::SUM_W;
   localparam int VW      = pgnms_pkg::VALUE_W;
   localparam int DW      = pgnms_pkg::DIST_W;

   // captured transaction
   logic [4:0]    cell_row_ff, cell_col_ff, pos_row_ff, pos_col_ff;
   logic [VW-1:0] cell_value_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cell_row_ff   <= req_cell_row;
         cell_col_ff   <= req_cell_col;
         cell_value_ff <= req_cell_value;
         pos_row_ff    <= req_pos_row;
         pos_col_ff    <= req_pos_col;
      end
   end

   logic             wr_ok;
   logic [15:0]      wr_lin;
   logic [IDX_W-1:0] wr_idx;

   assign wr_ok  = ({4'b0, cell_row_ff} < 9'(ROWS)) && ({4'b0, cell_col_ff} < 9'(COLS));
   assign wr_lin = 16'(cell_row_ff) * 16'(COLS) + 16'(cell_col_ff);
   assign wr_idx = wr_lin[IDX_W-1:0];

   // clearing pass counter
   logic [IDX_W-1:0] clr_addr_ff, clr_addr_in;
   assign clr_addr_in = cmd.clr_we ? clr_addr_ff + IDX_W'(1) : clr_addr_ff;

   // scan counters, column outer and row inner
   logic [RW-1:0]    row_ff, row_in;
   logic [CW-1:0]    col_ff, col_in;
   logic [IDX_W-1:0] addr_ff, addr_in;
   logic [CW:0]      col_inc;
   logic             row_last, col_last;

   assign row_last = (row_ff == RW'(ROWS - 1));
   assign col_last = (col_ff == CW'(COLS - 1));
   assign col_inc  = {1'b0, col_ff} + (CW + 1)'(1);

   always_comb begin
      row_in  = row_ff;
      col_in  = col_ff;
      addr_in = addr_ff;
      if (cmd.scan_start) begin
         row_in  = '0;
         col_in  = '0;
         addr_in = '0;
      end else if (cmd.scan_issue) begin
         if (row_last) begin
            row_in  = '0;
            col_in  = col_inc[CW-1:0];
            addr_in = IDX_W'(col_inc);
         end else begin
            row_in  = row_ff + RW'(1);
            addr_in = addr_ff + IDX_W'(COLS);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else begin
         clr_addr_ff <= clr_addr_in;
      end
      row_ff  <= row_in;
      col_ff  <= col_in;
      addr_ff <= addr_in;
   end

   assign st.clr_last  = (clr_addr_ff == IDX_W'(CELLS - 1));
   assign st.scan_last = row_last && col_last;
   assign st.wr_ok     = wr_ok;

   // grid memory: one write port, one registered read port
   logic [VW-1:0]    mem [CELLS];
   logic [VW-1:0]    rd_data_ff;
   logic [IDX_W-1:0] rd_addr, wa;
   logic             we;
   logic [VW-1:0]    wd;

   assign rd_addr = cmd.wr_rd ? wr_idx : addr_ff;
   assign we      = cmd.clr_we || cmd.wr_we;
   assign wa      = cmd.clr_we ? clr_addr_ff : wr_idx;
   assign wd      = cmd.clr_we ? '0 : cell_value_ff;

   always_ff @(posedge clock) begin
      if (we) mem[wa] <= wd;
      rd_data_ff <= mem[rd_addr];
   end

   // running total
   logic [TOTAL_W-1:0] total_ff, total_in;
   assign total_in = cmd.wr_we ?
                     total_ff - TOTAL_W'(rd_data_ff) + TOTAL_W'(cell_value_ff) : total_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
      end else begin
         total_ff <= total_in;
      end
   end

   // stage 1: squared coordinate distances, aligned with the read data
   logic [7:0]    r8, c8, pr8, pc8, dr, dc;
   logic [15:0]   sq_r_ff, sq_c_ff;
   logic [RW-1:0] s1_row_ff;
   logic [CW-1:0] s1_col_ff;
   logic          s1_valid_ff;

   assign r8  = 8'(row_ff);
   assign c8  = 8'(col_ff);
   assign pr8 = {3'b0, pos_row_ff};
   assign pc8 = {3'b0, pos_col_ff};
   assign dr  = (r8 > pr8) ? r8 - pr8 : pr8 - r8;
   assign dc  = (c8 > pc8) ? c8 - pc8 : pc8 - c8;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.scan_issue;
      end
      sq_r_ff   <= 16'(dr) * 16'(dr);
      sq_c_ff   <= 16'(dc) * 16'(dc);
      s1_row_ff <= row_ff;
      s1_col_ff <= col_ff;
   end

   // stage 2: keep the best candidate (higher value, then nearer, then first)
   logic          have_ff, have_in;
   logic [VW-1:0] best_v_ff;
   logic [DW-1:0] best_d_ff, cand_dist;
   logic [RW-1:0] best_r_ff;
   logic [CW-1:0] best_c_ff;
   logic          take;

   assign cand_dist = DW'(sq_r_ff) + DW'(sq_c_ff);
   assign take = s1_valid_ff &&
                 (!have_ff || (rd_data_ff > best_v_ff) ||
                  ((rd_data_ff == best_v_ff) && (cand_dist < best_d_ff)));

   always_comb begin
      have_in = have_ff;
      if (cmd.scan_start) have_in = 1'b0;
      else if (take)      have_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff <= 1'b0;
      end else begin
         have_ff <= have_in;
      end
      if (take) begin
         best_v_ff <= rd_data_ff;
         best_d_ff <= cand_dist;
         best_r_ff <= s1_row_ff;
         best_c_ff <= s1_col_ff;
      end
   end

   // result register
   logic [7:0]                 br8, bc8;
   logic [EXT_W-1:0]           total_ext;
   logic [pgnms_pkg::SUM_W-1:0] sum_sat;

   assign br8       = 8'(best_r_ff);
   assign bc8       = 8'(best_c_ff);
   assign total_ext = EXT_W'(total_ff);
   assign sum_sat   = (total_ext > EXT_W'(pgnms_pkg::SUM_MAX)) ?
                      pgnms_pkg::SUM_MAX : total_ext[pgnms_pkg::SUM_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_remaining_sum <= sum_sat;
         if (cmd.out_search) begin
            rsp_best_row   <= br8[4:0];
            rsp_best_col   <= bc8[4:0];
            rsp_best_value <= best_v_ff;
         end else begin
            rsp_best_row   <= cell_row_ff;
            rsp_best_col   <= cell_col_ff;
            rsp_best_value <= wr_ok ? cell_value_ff : '0;
         end
      end
   end

endmodule

// ===== sv/priority_grid_nearest_max_select.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_grid_nearest_max_select
// Grid of 8-bit cell priorities with cell writes and a nearest-max search.
// ----------------------------------------------------------------------------
// Sequencing: one transaction at a time. A write reads its cell, then
//   updates it (skipped for a cell outside the grid) and emits the result.
//   A search scans the grid at one grid read per cycle, then drains and
//   emits. The result loads only when the output register is free.
// Reset: a clearing pass zeroes the grid with req_tready low; the total and
//   all control state clear at once.
module priority_grid_nearest_max_select #(
   parameter int ROWS = 32,
   parameter int COLS = 32
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   // [4:0] cell_row, [9:5] cell_col, [17:10] cell_value, [22:18] pos_row,
   // [27:23] pos_col, [31:28] zero
   input  logic [31:0] req_tdata,
   // [0] cmd: 0 write one cell, 1 search from a position
   input  logic        req_tuser,
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [4:0] best_row, [9:5] best_col, [17:10] best_value,
   // [35:18] remaining_sum, [39:36] zero
   output logic [39:0] rsp_tdata
);

   pgnms_pkg::cmd_type    cmd;
   pgnms_pkg::status_type st;

   logic [pgnms_pkg::COORD_W-1:0] best_row, best_col;
   logic [pgnms_pkg::VALUE_W-1:0] best_value;
   logic [pgnms_pkg::SUM_W-1:0]   remaining_sum;
   logic                          req_search;

   assign req_search = (req_tuser == pgnms_pkg::CMD_SEARCH);

   // Controller: walks the clearing pass, the read-modify-write of a cell
   // (old value is needed to keep the running total) and the full-grid scan,
   // then parks the result in the output register. A result waits there until
   // taken; the next result loads only once the register is free.
   pgnms_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_search (req_search),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .st         (st),
      .cmd        (cmd)
   );

   // Datapath: grid memory, scan address walk (column outer, row inner),
   // squared distance stage and the best-candidate compare. Ties on value go
   // to the nearer cell; a further tie keeps the earlier cell in scan order.
   pgnms_datapath #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .st                (st),
      .req_cell_row      (req_tdata[4:0]),
      .req_cell_col      (req_tdata[9:5]),
      .req_cell_value    (req_tdata[17:10]),
      .req_pos_row       (req_tdata[22:18]),
      .req_pos_col       (req_tdata[27:23]),
      .rsp_best_row      (best_row),
      .rsp_best_col      (best_col),
      .rsp_best_value    (best_value),
      .rsp_remaining_sum (remaining_sum)
   );

   assign rsp_tdata = {4'b0, remaining_sum, best_value, best_col, best_row};

endmodule
